@@ hdl/tdq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared constants, codes and controller/datapath interface types for the
// timer deadline queue.
// ----------------------------------------------------------------------------
package tdq_pkg;

  localparam int CAPACITY      = 16;
  localparam int HANDLE_BITS   = 16;
  localparam int SLOT_BITS     = $clog2(CAPACITY);
  localparam int TIME_BITS     = 48;
  localparam int WAIT_BITS     = 32;
  localparam int INTERVAL_BITS = 32;
  localparam int ADVANCE_BITS  = 20;
  localparam int HOUT_BITS     = 16;
  localparam int HCMP_BITS     = (HANDLE_BITS > HOUT_BITS) ? HANDLE_BITS : HOUT_BITS;

  localparam logic [WAIT_BITS-1:0] IDLE_WAIT_RESET = 32'd60000000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_CANCEL  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_WAIT    = 2'd3;

  typedef struct packed {
    logic accept;
    logic scan_start;
    logic scan_wait;
    logic emit_due;
    logic emit_wait;
  } tdq_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
  } tdq_status_t;

endpackage

@@ hdl/tdq_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_ctrl
// Sequencer: takes requests, runs the due-entry scans of a tick and the
// final wait scan.
// ----------------------------------------------------------------------------
module tdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         operation,
  output logic               busy,
  output tdq_pkg::tdq_cmd_t  cmd,
  input  tdq_pkg::tdq_status_t status
);
  import tdq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DUE, S_WAIT} state_t;

  state_t state;

  always_comb begin
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept     = 1'b1;
          cmd.scan_start = (operation == OP_TICK);
        end
      end
      S_DUE: begin
        if (status.scan_done) begin
          // rescan after each emitted entry, then switch to the wait scan
          cmd.scan_start = 1'b1;
          cmd.emit_due   = status.found;
          cmd.scan_wait  = !status.found;
        end
      end
      S_WAIT: begin
        cmd.emit_wait = status.scan_done;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start && operation == OP_TICK) begin
            state <= S_DUE;
            busy  <= 1'b1;
          end
        end
        S_DUE: begin
          if (status.scan_done && !status.found) state <= S_WAIT;
        end
        S_WAIT: begin
          if (status.scan_done) begin
            state <= S_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule

@@ hdl/tdq_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_dp
// Slot table, time counter, handle counter, two-stage slot scanner and
// result registers.
// ----------------------------------------------------------------------------
module tdq_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  tdq_pkg::tdq_cmd_t                      cmd,
  output tdq_pkg::tdq_status_t                   status,
  input  logic [1:0]                             operation,
  input  logic [tdq_pkg::INTERVAL_BITS-1:0]      interval_us,
  input  logic [tdq_pkg::HOUT_BITS-1:0]          target_handle,
  input  logic [tdq_pkg::ADVANCE_BITS-1:0]       advance_us,
  input  logic                                   cfg_write,
  input  logic [tdq_pkg::WAIT_BITS-1:0]          cfg_data,
  output logic                                   result_valid,
  output logic [1:0]                             kind,
  output logic [tdq_pkg::HOUT_BITS-1:0]          handle,
  output logic                                   ok,
  output logic [tdq_pkg::TIME_BITS-1:0]          elapsed_us,
  output logic [tdq_pkg::WAIT_BITS-1:0]          wait_us,
  output logic                                   last
);
  import tdq_pkg::*;

  function automatic logic [HOUT_BITS-1:0] hout(input logic [HANDLE_BITS-1:0] h);
    logic [HCMP_BITS-1:0] x;
    x = HCMP_BITS'(h);
    return x[HOUT_BITS-1:0];
  endfunction

  logic [TIME_BITS-1:0]   now_us;
  logic [HANDLE_BITS-1:0] next_handle;
  logic [WAIT_BITS-1:0]   idle_wait;
  logic [CAPACITY-1:0]    slot_valid;
  logic [TIME_BITS-1:0]   slot_start    [CAPACITY];
  logic [TIME_BITS-1:0]   slot_interval [CAPACITY];
  logic [HANDLE_BITS-1:0] slot_handle   [CAPACITY];

  logic                   free_hit, match_hit;
  logic [SLOT_BITS-1:0]   free_idx, match_idx;

  logic                   scan_active, scan_wait_mode;
  logic [SLOT_BITS-1:0]   scan_idx;
  logic                   s1_issue, s1_v;
  logic [TIME_BITS-1:0]   s1_el, s1_iv;
  logic [HANDLE_BITS-1:0] s1_h;
  logic [SLOT_BITS-1:0]   s1_idx;

  logic                   found;
  logic [TIME_BITS-1:0]   best_val, best_el;
  logic [HANDLE_BITS-1:0] best_h;
  logic [SLOT_BITS-1:0]   best_idx;

  logic [TIME_BITS-1:0]   over, wdist;
  logic                   take_due, take_wait;

  always_comb begin
    free_hit  = 1'b0;
    free_idx  = '0;
    match_hit = 1'b0;
    match_idx = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = SLOT_BITS'(i);
      end
      if (slot_valid[i] &&
          HCMP_BITS'(slot_handle[i]) == HCMP_BITS'(target_handle)) begin
        match_hit = 1'b1;
        match_idx = SLOT_BITS'(i);
      end
    end
  end

  assign over  = s1_el - s1_iv;
  assign wdist = s1_iv - s1_el;
  assign take_due = s1_issue && !scan_wait_mode && s1_v && (s1_el >= s1_iv) &&
                    (!found || over > best_val ||
                     (over == best_val && s1_h < best_h));
  assign take_wait = s1_issue && scan_wait_mode && s1_v && (!found || wdist < best_val);

  assign status.scan_done = !scan_active && !s1_issue;
  assign status.found     = found;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      now_us       <= '0;
      next_handle  <= '0;
      idle_wait    <= IDLE_WAIT_RESET;
      slot_valid   <= '0;
      scan_active  <= 1'b0;
      s1_issue     <= 1'b0;
      found        <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (cmd.accept && (operation == OP_START || operation == OP_CANCEL)) ||
                      cmd.emit_due || cmd.emit_wait;
      if (cfg_write) idle_wait <= cfg_data;
      if (cmd.accept) begin
        unique case (operation)
          OP_START: begin
            if (free_hit) begin
              slot_valid[free_idx] <= 1'b1;
              next_handle          <= next_handle + 1'b1;
            end
          end
          OP_CANCEL: begin
            if (match_hit) slot_valid[match_idx] <= 1'b0;
          end
          OP_TICK: now_us <= now_us + TIME_BITS'(advance_us);
          default: begin
          end
        endcase
      end
      if (cmd.emit_due) slot_valid[best_idx] <= 1'b0;

      s1_issue <= scan_active;
      if (scan_active && scan_idx == SLOT_BITS'(CAPACITY - 1)) scan_active <= 1'b0;
      if (take_due || take_wait) found <= 1'b1;
      if (cmd.scan_start) begin
        scan_active <= 1'b1;
        found       <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept && operation == OP_START && free_hit) begin
      slot_start[free_idx]    <= now_us;
      slot_interval[free_idx] <= TIME_BITS'(interval_us);
      slot_handle[free_idx]   <= next_handle;
    end

    if (cmd.scan_start) begin
      scan_idx       <= '0;
      scan_wait_mode <= cmd.scan_wait;
    end else if (scan_active) begin
      scan_idx <= scan_idx + 1'b1;
    end
    s1_v   <= slot_valid[scan_idx];
    s1_el  <= now_us - slot_start[scan_idx];
    s1_iv  <= slot_interval[scan_idx];
    s1_h   <= slot_handle[scan_idx];
    s1_idx <= scan_idx;

    if (take_due) begin
      best_val <= over;
      best_el  <= s1_el;
      best_h   <= s1_h;
      best_idx <= s1_idx;
    end else if (take_wait) begin
      best_val <= wdist;
    end

    if (cmd.accept) begin
      kind       <= (operation == OP_START) ? KIND_START : KIND_CANCEL;
      ok         <= (operation == OP_START) ? free_hit : match_hit;
      handle     <= (operation == OP_START) ? (free_hit ? hout(next_handle) : '0)
                                            : target_handle;
      elapsed_us <= '0;
      wait_us    <= '0;
      last       <= 1'b1;
    end else if (cmd.emit_due) begin
      kind       <= KIND_EXPIRED;
      ok         <= 1'b1;
      handle     <= hout(best_h);
      elapsed_us <= best_el;
      wait_us    <= '0;
      last       <= 1'b0;
    end else if (cmd.emit_wait) begin
      kind       <= KIND_WAIT;
      ok         <= 1'b1;
      handle     <= '0;
      elapsed_us <= '0;
      wait_us    <= found ? best_val[WAIT_BITS-1:0] : idle_wait;
      last       <= 1'b1;
    end
  end

  a_emit_needs_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_due |-> found)
    else $error("expired result emitted without a due entry");

  a_scan_restart_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_start |-> (!scan_active && !s1_issue))
    else $error("scan restarted while running");

  a_wait_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && kind == KIND_WAIT) |-> last)
    else $error("wait report not marked last");

  a_due_clears_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_due |=> !slot_valid[$past(best_idx)])
    else $error("expired slot still valid");

endmodule

@@ hdl/timer_deadline_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue
// Table of pending timeouts with a microsecond counter: start, cancel, tick.
// ----------------------------------------------------------------------------
// Start and cancel requests: reply strobed in the cycle after accept, busy stays
// low, so a request may be taken every cycle.
// Tick: the one-slot-per-cycle scanner runs a due scan, a rescan after each
// expiration and a final wait scan; busy stays high until the wait scan ends.
// Results are strobed once each; the receiver cannot stall.
// Reset clears the time and handle counters and empties the table.
module timer_deadline_queue (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           operation,
  input  logic [tdq_pkg::INTERVAL_BITS-1:0]    interval_us,
  input  logic [tdq_pkg::HOUT_BITS-1:0]        target_handle,
  input  logic [tdq_pkg::ADVANCE_BITS-1:0]     advance_us,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tdq_pkg::WAIT_BITS-1:0]        cfg_data,
  output logic                                 result_valid,
  output logic [1:0]                           kind,
  output logic [tdq_pkg::HOUT_BITS-1:0]        handle,
  output logic                                 ok,
  output logic [tdq_pkg::TIME_BITS-1:0]        elapsed_us,
  output logic [tdq_pkg::WAIT_BITS-1:0]        wait_us,
  output logic                                 last
);
  import tdq_pkg::*;

  tdq_cmd_t    cmd;
  tdq_status_t status;

  assign cfg_ready = !busy;

  tdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status)
  );

  tdq_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .operation     (operation),
    .interval_us   (interval_us),
    .target_handle (target_handle),
    .advance_us    (advance_us),
    .cfg_write     (cfg_valid && cfg_ready),
    .cfg_data      (cfg_data),
    .result_valid  (result_valid),
    .kind          (kind),
    .handle        (handle),
    .ok            (ok),
    .elapsed_us    (elapsed_us),
    .wait_us       (wait_us),
    .last          (last)
  );

endmodule

@@ test/timer_deadline_queue_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_deadline_queue_test
// Self-checking bench for the timer deadline queue. A directed table covers
// empty ticks, zero and maximum intervals, cancel hits and misses, a full
// table and the unused operation code. A short start/cancel/tick sequence
// follows, then random traffic under several idle-wait settings.
// Every reply is checked field by field against an in-bench table predictor.
// ----------------------------------------------------------------------------
module timer_deadline_queue_test;
  import tdq_pkg::*;

  localparam int LIMIT_CYCLES = 4000000;
  localparam int SETTLE       = 400;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] handle;
    logic        ok;
    logic [47:0] elapsed;
    logic [31:0] wait_val;
    logic        last;
  } reply_t;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] iv;
    logic [15:0] th;
    logic [19:0] adv;
    bit          chk;
    logic [15:0] x_handle;
    logic        x_ok;
    logic [31:0] x_wait;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = OP_START;
  logic [INTERVAL_BITS-1:0] interval_us = '0;
  logic [HOUT_BITS-1:0] target_handle = '0;
  logic [ADVANCE_BITS-1:0] advance_us = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [WAIT_BITS-1:0] cfg_data = '0;
  logic result_valid;
  logic [1:0] kind;
  logic [HOUT_BITS-1:0] handle;
  logic ok;
  logic [TIME_BITS-1:0] elapsed_us;
  logic [WAIT_BITS-1:0] wait_us;
  logic last;

  // predicted block state
  logic [47:0] now_t;
  logic [15:0] next_h;
  bit          live [CAPACITY];
  logic [47:0] t_start [CAPACITY];
  logic [47:0] t_dead [CAPACITY];
  logic [15:0] t_handle [CAPACITY];
  logic [31:0] idle_wait;

  reply_t pending_replies[$];
  row_t   dir_rows[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_expired = 0;
  int n_rejected = 0;

  timer_deadline_queue uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout, %0d replies outstanding", $time, pending_replies.size());
      $display("[timer_deadline_queue] ERROR");
      $finish;
    end
  end

  function automatic void queue_reply(logic [1:0] k, logic [15:0] h, logic o,
                                      logic [47:0] el, logic [31:0] w, logic l);
    reply_t r;
    r.kind = k; r.handle = h; r.ok = o; r.elapsed = el; r.wait_val = w; r.last = l;
    pending_replies.push_back(r);
  endfunction

  function automatic void table_predict(logic [1:0] op, logic [31:0] iv, logic [15:0] th,
                                        logic [19:0] adv);
    int best;
    bit done;
    bit any;
    logic [47:0] el, ivl, over, bover, w, wmin;
    done = 0;
    case (op)
      OP_START: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!done && !live[i]) begin
            live[i] = 1; t_start[i] = now_t; t_dead[i] = now_t + {16'd0, iv};
            t_handle[i] = next_h;
            queue_reply(KIND_START, next_h, 1'b1, '0, '0, 1'b1);
            next_h = next_h + 16'd1;
            done = 1;
          end
        end
        if (!done) begin
          queue_reply(KIND_START, '0, 1'b0, '0, '0, 1'b1);
          n_rejected++;
        end
      end
      OP_CANCEL: begin
        for (int i = 0; i < CAPACITY; i++) begin
          if (!done && live[i] && t_handle[i] == th) begin
            live[i] = 0;
            done = 1;
          end
        end
        queue_reply(KIND_CANCEL, th, done, '0, '0, 1'b1);
      end
      OP_TICK: begin
        now_t = now_t + {28'd0, adv};
        while (1) begin
          best = -1;
          bover = '0;
          for (int i = 0; i < CAPACITY; i++) begin
            if (live[i]) begin
              el = now_t - t_start[i];
              ivl = t_dead[i] - t_start[i];
              if (el >= ivl) begin
                over = el - ivl;
                if (best < 0 || over > bover ||
                    (over == bover && t_handle[i] < t_handle[best])) begin
                  best = i;
                  bover = over;
                end
              end
            end
          end
          if (best < 0) break;
          queue_reply(KIND_EXPIRED, t_handle[best], 1'b1, now_t - t_start[best], '0, 1'b0);
          live[best] = 0;
          n_expired++;
        end
        any = 0;
        wmin = '0;
        for (int i = 0; i < CAPACITY; i++) begin
          if (live[i]) begin
            w = (t_dead[i] - t_start[i]) - (now_t - t_start[i]);
            if (!any || w < wmin) wmin = w;
            any = 1;
          end
        end
        queue_reply(KIND_WAIT, '0, 1'b1, '0, any ? wmin[31:0] : idle_wait, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    reply_t r;
    if (!rst && result_valid) begin
      if (pending_replies.size() == 0) begin
        $display("%0t unexpected reply kind %0d handle %0h", $time, kind, handle);
        errors++;
      end else begin
        r = pending_replies.pop_front();
        check_field("kind", 48'(r.kind), 48'(kind));
        check_field("handle", 48'(r.handle), 48'(handle));
        check_field("ok", 48'(r.ok), 48'(ok));
        check_field("elapsed_us", r.elapsed, elapsed_us);
        check_field("wait_us", 48'(r.wait_val), 48'(wait_us));
        check_field("last", 48'(r.last), 48'(last));
      end
    end
  end

  task automatic send(input logic [1:0] op, input logic [31:0] iv, input logic [15:0] th,
                      input logic [19:0] adv, input bit allow_gap);
    int gap;
    gap = 0;
    if (allow_gap && $urandom_range(99) < 35) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    operation <= op;
    interval_us <= iv;
    target_handle <= th;
    advance_us <= adv;
    do @(posedge clk); while (busy);
    table_predict(op, iv, th, adv);
    n_items++;
  endtask

  // drain all replies and let the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_idle_wait(input logic [31:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    idle_wait = v;
  endtask

  task automatic random_traffic(input int count, input bit quiet_stretch);
    int r, sel, slot;
    logic [1:0] op;
    logic [31:0] iv;
    logic [15:0] th;
    logic [19:0] adv;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(99);
      sel = $urandom_range(9);
      iv = $urandom;
      th = 16'($urandom);
      adv = 20'($urandom);
      if (r < 40) begin
        op = OP_START;
        if (sel < 6) iv = $urandom_range(3000);
        else if (sel < 7) iv = '0;
        else if (sel < 8) iv = 32'hFFFF_FFFF;
      end else if (r < 65) begin
        op = OP_CANCEL;
        slot = $urandom_range(CAPACITY - 1);
        if (sel < 7 && live[slot]) th = t_handle[slot];
      end else if (r < 95) begin
        op = OP_TICK;
        if (sel < 7) adv = 20'($urandom_range(2000));
        else if (sel < 8) adv = '0;
        else if (sel < 9) adv = 20'hFFFFF;
      end else begin
        op = 2'd3;
      end
      send(op, iv, th, adv, !(quiet_stretch && k >= 60 && k < 140));
    end
  endtask

  function automatic void add_row(logic [1:0] op, logic [31:0] iv, logic [15:0] th,
                                  logic [19:0] adv, bit chk, logic [15:0] xh, logic xo,
                                  logic [31:0] xw);
    row_t w;
    w.op = op; w.iv = iv; w.th = th; w.adv = adv;
    w.chk = chk; w.x_handle = xh; w.x_ok = xo; w.x_wait = xw;
    dir_rows.push_back(w);
  endfunction

  initial begin
    logic [15:0] keep;
    int top;
    now_t = '0;
    next_h = '0;
    idle_wait = IDLE_WAIT_RESET;
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = 0; t_start[i] = '0; t_dead[i] = '0; t_handle[i] = '0;
    end

    add_row(OP_TICK, '0, '0, '0, 1, 16'd0, 1'b1, 32'd60000000);
    add_row(OP_START, '0, '0, '0, 1, 16'd0, 1'b1, '0);
    add_row(OP_TICK, '0, '0, '0, 0, '0, '0, '0);
    add_row(OP_START, 32'hFFFF_FFFF, '0, '0, 1, 16'd1, 1'b1, '0);
    add_row(OP_CANCEL, '0, 16'd1, '0, 1, 16'd1, 1'b1, '0);
    add_row(OP_CANCEL, '0, 16'd1, '0, 1, 16'd1, 1'b0, '0);
    add_row(OP_CANCEL, '0, 16'hFFFF, '0, 1, 16'hFFFF, 1'b0, '0);
    add_row(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF, 0, '0, '0, '0);
    for (int k = 0; k < CAPACITY; k++)
      add_row(OP_START, 32'(k * 7), '0, '0, 1, 16'(2 + k), 1'b1, '0);
    add_row(OP_START, 32'd5, '0, '0, 1, 16'd0, 1'b0, '0);   // table full
    add_row(OP_TICK, '0, '0, 20'hFFFFF, 0, '0, '0, '0);
    add_row(OP_CANCEL, '0, 16'd17, '0, 0, '0, '0, '0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      send(dir_rows[n].op, dir_rows[n].iv, dir_rows[n].th, dir_rows[n].adv, 1);
      if (dir_rows[n].chk) begin
        top = pending_replies.size() - 1;
        pending_replies[top].handle = dir_rows[n].x_handle;
        pending_replies[top].ok = dir_rows[n].x_ok;
        pending_replies[top].wait_val = dir_rows[n].x_wait;
      end
    end

    // park a long and a short entry, cancel the long one, expire the short one, then cancel the long one again
    drain();
    for (int i = 0; i < CAPACITY; i++)
      if (live[i]) send(OP_CANCEL, '0, t_handle[i], '0, 0);
    keep = next_h;
    send(OP_START, 32'hFFFF_FFFF, '0, '0, 0);
    send(OP_START, 32'd3, '0, '0, 0);
    send(OP_CANCEL, '0, keep, '0, 1);
    send(OP_TICK, '0, '0, 20'd3, 1);
    send(OP_CANCEL, '0, keep, '0, 1);

    write_idle_wait('0);
    random_traffic(150, 1);
    write_idle_wait(32'hFFFF_FFFF);
    random_traffic(150, 0);
    write_idle_wait($urandom);
    random_traffic(150, 0);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests: %0d expirations, %0d starts rejected on a full table,",
             n_items, n_expired, n_rejected);
    $display("cancel hits and misses and three idle-wait settings.");
    if (errors == 0 && pending_replies.size() == 0) begin
      $display("[timer_deadline_queue] OK");
    end else begin
      $display("%0t %0d mismatches, %0d replies missing", $time, errors,
               pending_replies.size());
      $display("[timer_deadline_queue] ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/tdq_pkg.sv
hdl/tdq_ctrl.sv
hdl/tdq_dp.sv
hdl/timer_deadline_queue.sv
test/timer_deadline_queue_test.sv
